[src/stt_pkg.sv]
// shared types, constants and arithmetic helpers of the station trend tracker
package stt_pkg;

	localparam int FAST_WIN = 5;
	localparam int SLOW_WIN = 60;
	localparam int LADDER   = 6;
	localparam int LEN_W    = 9;

	// reciprocals scaled so that the truncated product is exact over the sum ranges
	localparam int FAST_SHIFT = 17;
	localparam int SLOW_SHIFT = 24;
	localparam logic [14:0] FAST_RECIP = 15'(((1 << FAST_SHIFT) + FAST_WIN - 1) / FAST_WIN);
	localparam logic [18:0] SLOW_RECIP = 19'(((1 << SLOW_SHIFT) + SLOW_WIN - 1) / SLOW_WIN);

	localparam logic [12:0] TEMP_STEPS [LADDER] = '{13'd5, 13'd10, 13'd20, 13'd30, 13'd40, 13'd50};
	localparam logic [12:0] HUMI_STEPS [LADDER] = '{13'd2, 13'd4, 13'd8, 13'd10, 13'd12, 13'd14};

	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef enum logic [1:0] {
		PH_NEW    = 2'd0,
		PH_HEARD  = 2'd1,
		PH_SEEDED = 2'd2
	} stt_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REP_RD,
		ST_REP_WR,
		ST_TK_RD,
		ST_TK_S1,
		ST_TK_S2,
		ST_TK_S3,
		ST_TK_OUT
	} stt_state_t;

	typedef struct packed {
		logic signed [10:0] temp;
		logic [6:0]         humi;
		stt_phase_t         phase;
		logic               heard;
		logic signed [13:0] fast_t;
		logic signed [17:0] slow_t;
		logic [9:0]         fast_h;
		logic [12:0]        slow_h;
	} stt_row_t;

	typedef struct packed {
		logic s1_en;
		logic s2_en;
		logic s3_en;
	} stt_ctl_t;

	// signed divide by the fast window, truncating toward zero
	function automatic logic signed [13:0] div_fast(input logic signed [13:0] v);
		logic [13:0] m;
		logic [28:0] p;
		logic [13:0] q;
		m = v[13] ? 14'(-v) : 14'(v);
		p = 29'(m) * 29'(FAST_RECIP);
		q = 14'(p >> FAST_SHIFT);
		return v[13] ? -$signed(q) : $signed(q);
	endfunction

	// signed divide by the slow window, truncating toward zero
	function automatic logic signed [17:0] div_slow(input logic signed [17:0] v);
		logic [17:0] m;
		logic [36:0] p;
		logic [17:0] q;
		m = v[17] ? 18'(-v) : 18'(v);
		p = 37'(m) * 37'(SLOW_RECIP);
		q = 18'(p >> SLOW_SHIFT);
		return v[17] ? -$signed(q) : $signed(q);
	endfunction

	// number of ladder steps at or below the magnitude, with the sign of the difference
	function automatic logic signed [3:0] quantize(input logic signed [12:0] d, input logic humi);
		logic [12:0] mag;
		logic [3:0]  lvl;
		mag = d[12] ? 13'(-d) : 13'(d);
		lvl = '0;
		for (int i = 0; i < LADDER; i++) begin
			if (mag >= (humi ? HUMI_STEPS[i] : TEMP_STEPS[i])) begin
				lvl = lvl + 4'd1;
			end
		end
		return d[12] ? -$signed(lvl) : $signed(lvl);
	endfunction

endpackage

[src/station_trend_tracker_unit.sv]
// report: the station row is read and written back; no result word
// tick: one station after another through the row memory
// (read, divide, update, divide, quantize), giving NUM_STATIONS result words;
// a stalled result word holds the walk in place
// one item is taken at a time; in_stall stays high until the item is finished
// reset: all stations read as never reported with zero sums and history, history_length = 80
module station_trend_tracker_unit #(
	parameter int NUM_STATIONS = 4,
	parameter int HISTORY_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [7:0]        cfg_write_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [3:0]        station,
	input  logic signed [10:0] temp_tenths,
	input  logic [6:0]        humidity,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        station_index,
	output logic signed [3:0] temp_trend,
	output logic signed [3:0] humi_trend,
	output logic              heard_recently,
	output logic              last
);
	import stt_pkg::*;

	localparam int AW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int RW = $bits(stt_row_t);

	stt_state_t state_q, state_nx;
	stt_ctl_t ctl;

	logic [7:0] hl_q;
	logic [LEN_W-1:0] len;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] rep_addr_q;
	logic signed [10:0] temp_q;
	logic [6:0] humi_q;

	logic in_acc;
	logic rep_ok;
	logic cnt_last;
	logic out_load;

	logic [AW-1:0] raddr, waddr;
	logic [RW-1:0] row_rdata, row_wdata;
	logic row_we;
	stt_row_t row_rd, rep_row, row_s2;
	logic [HISTORY_DEPTH-1:0] hist_rdata, hist_s1;
	logic hist_we;
	logic any_s2;
	logic signed [3:0] temp_lvl, humi_lvl;

	logic out_valid_q;

	assign in_acc   = in_valid && !in_stall;
	assign rep_ok   = ({1'b0, station} < 5'(NUM_STATIONS));
	assign cnt_last = (cnt_q == AW'(NUM_STATIONS - 1));
	assign out_load = (state_q == ST_TK_OUT) && (!out_valid_q || !out_stall);

	// window length limited to one and to the history depth
	always_comb begin
		if (hl_q == 8'd0) begin
			len = LEN_W'(1);
		end else if ({1'b0, hl_q} > LEN_W'(HISTORY_DEPTH)) begin
			len = LEN_W'(HISTORY_DEPTH);
		end else begin
			len = {1'b0, hl_q};
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (action == ACT_TICK) begin
						state_nx = ST_TK_RD;
					end else if (rep_ok) begin
						state_nx = ST_REP_RD;
					end
				end
			end
			ST_REP_RD: state_nx = ST_REP_WR;
			ST_REP_WR: state_nx = ST_IDLE;
			ST_TK_RD:  state_nx = ST_TK_S1;
			ST_TK_S1:  state_nx = ST_TK_S2;
			ST_TK_S2:  state_nx = ST_TK_S3;
			ST_TK_S3:  state_nx = ST_TK_OUT;
			ST_TK_OUT: begin
				if (out_load) begin
					state_nx = cnt_last ? ST_IDLE : ST_TK_RD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ctl.s1_en = (state_q == ST_TK_S1);
		ctl.s2_en = (state_q == ST_TK_S2);
		ctl.s3_en = (state_q == ST_TK_S3);
		raddr     = (state_q == ST_REP_RD) ? rep_addr_q : cnt_q;
		waddr     = (state_q == ST_REP_WR) ? rep_addr_q : cnt_q;
		row_we    = (state_q == ST_REP_WR) || (state_q == ST_TK_S3);
		hist_we   = (state_q == ST_TK_S3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hl_q        <= 8'd80;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_write_en) begin
				hl_q <= cfg_write_data;
			end
			if (out_load) begin
				cnt_q <= cnt_last ? '0 : cnt_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rep_addr_q <= station[AW-1:0];
			temp_q     <= temp_tenths;
			humi_q     <= humidity;
		end
		if (out_load) begin
			station_index  <= 4'(cnt_q);
			temp_trend     <= temp_lvl;
			humi_trend     <= humi_lvl;
			heard_recently <= any_s2;
			last           <= cnt_last;
		end
	end

	// report modifies the row it has just read; a tick writes the updated row
	assign row_rd = stt_row_t'(row_rdata);

	always_comb begin
		rep_row       = row_rd;
		rep_row.temp  = temp_q;
		rep_row.humi  = humi_q;
		rep_row.heard = 1'b1;
		if (row_rd.phase == PH_NEW) begin
			rep_row.phase = PH_HEARD;
		end
	end

	assign row_wdata = (state_q == ST_REP_WR) ? RW'(rep_row) : RW'(row_s2);
	assign out_valid = out_valid_q;

	stt_ram #(.W(RW), .DEPTH(NUM_STATIONS)) u_row_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (row_rdata),
		.we     (row_we),
		.waddr  (waddr),
		.wdata  (row_wdata)
	);

	stt_ram #(.W(HISTORY_DEPTH), .DEPTH(NUM_STATIONS)) u_hist_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (hist_rdata),
		.we     (hist_we),
		.waddr  (waddr),
		.wdata  (hist_s1)
	);

	stt_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
		.clk     (clk),
		.ctl     (ctl),
		.hist_rd (hist_rdata),
		.heard   (row_rd.heard),
		.len     (len),
		.hist_s1 (hist_s1),
		.any_s2  (any_s2)
	);

	stt_avg u_avg (
		.clk      (clk),
		.ctl      (ctl),
		.row_rd   (row_rd),
		.row_s2   (row_s2),
		.temp_lvl (temp_lvl),
		.humi_lvl (humi_lvl)
	);

endmodule

[src/stt_ram.sv]
// synchronous row memory with registered read and per-row valid bits (unwritten rows read zero)
module stt_ram #(
	parameter int W = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;
	logic [DEPTH-1:0] vld_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

[src/stt_hist.sv]
// receive history shift over the active window and registered window-or
module stt_hist #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic                          clk,
	input  stt_pkg::stt_ctl_t             ctl,
	input  logic [HISTORY_DEPTH-1:0]      hist_rd,
	input  logic                          heard,
	input  logic [stt_pkg::LEN_W-1:0]     len,
	output logic [HISTORY_DEPTH-1:0]      hist_s1,
	output logic                          any_s2
);
	import stt_pkg::*;

	localparam int NCH = (HISTORY_DEPTH + 15) / 16;

	logic [HISTORY_DEPTH-1:0] shifted;
	logic [NCH-1:0] chunk;
	logic [NCH-1:0] chunk_s1;

	always_comb begin
		for (int x = 0; x < HISTORY_DEPTH; x++) begin
			if (LEN_W'(x + 1) < len) begin
				shifted[x] = hist_rd[(x + 1 < HISTORY_DEPTH) ? x + 1 : x];
			end else if (LEN_W'(x + 1) == len) begin
				shifted[x] = heard;
			end else begin
				shifted[x] = hist_rd[x];
			end
		end
	end

	// or of the window in groups of sixteen cells, finished in the next stage
	always_comb begin
		chunk = '0;
		for (int x = 0; x < HISTORY_DEPTH; x++) begin
			chunk[x >> 4] = chunk[x >> 4] | (shifted[x] & (LEN_W'(x) < len));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			hist_s1  <= shifted;
			chunk_s1 <= chunk;
		end
		if (ctl.s2_en) begin
			any_s2 <= |chunk_s1;
		end
	end

endmodule

[src/stt_avg.sv]
// running-sum average update, seeding and trend levels for one station row
module stt_avg (
	input  logic              clk,
	input  stt_pkg::stt_ctl_t ctl,
	input  stt_pkg::stt_row_t row_rd,
	output stt_pkg::stt_row_t row_s2,
	output logic signed [3:0] temp_lvl,
	output logic signed [3:0] humi_lvl
);
	import stt_pkg::*;

	stt_row_t row_s1;
	stt_row_t row_nx;
	logic signed [13:0] qft_s1;
	logic signed [17:0] qst_s1;
	logic signed [13:0] qfh_s1;
	logic signed [17:0] qsh_s1;
	logic signed [13:0] aft_s3;
	logic signed [17:0] ast_s3;
	logic signed [13:0] afh_s3;
	logic signed [17:0] ash_s3;

	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			row_s1 <= row_rd;
			qft_s1 <= div_fast(row_rd.fast_t);
			qst_s1 <= div_slow(row_rd.slow_t);
			qfh_s1 <= div_fast($signed({4'b0, row_rd.fast_h}));
			qsh_s1 <= div_slow($signed({5'b0, row_rd.slow_h}));
		end
		if (ctl.s2_en) begin
			row_s2 <= row_nx;
		end
		if (ctl.s3_en) begin
			aft_s3 <= div_fast(row_s2.fast_t);
			ast_s3 <= div_slow(row_s2.slow_t);
			afh_s3 <= div_fast($signed({4'b0, row_s2.fast_h}));
			ash_s3 <= div_slow($signed({5'b0, row_s2.slow_h}));
		end
	end

	always_comb begin
		row_nx = row_s1;
		row_nx.heard = 1'b0;
		case (row_s1.phase)
			PH_HEARD: begin
				row_nx.fast_t = 14'(row_s1.temp * FAST_WIN);
				row_nx.slow_t = 18'(row_s1.temp * SLOW_WIN);
				row_nx.fast_h = 10'(row_s1.humi * FAST_WIN);
				row_nx.slow_h = 13'(row_s1.humi * SLOW_WIN);
				row_nx.phase  = PH_SEEDED;
			end
			PH_SEEDED: begin
				row_nx.fast_t = row_s1.fast_t + 14'(row_s1.temp) - qft_s1;
				row_nx.slow_t = row_s1.slow_t + 18'(row_s1.temp) - qst_s1;
				row_nx.fast_h = row_s1.fast_h + 10'(row_s1.humi) - 10'(qfh_s1);
				row_nx.slow_h = row_s1.slow_h + 13'(row_s1.humi) - 13'(qsh_s1);
			end
			default: begin
				row_nx.phase = row_s1.phase;
			end
		endcase
	end

	assign temp_lvl = quantize(13'(aft_s3) - 13'(ast_s3), 1'b0);
	assign humi_lvl = quantize(13'(afh_s3) - 13'(ash_s3), 1'b1);

endmodule
